@@ rtl/rpc_pkg.sv @@
// Shared types and constants for the radio power request controller.
package rpc_pkg;

    localparam int OpWidth    = 3;
    localparam int ReqIdWidth = 4;
    localparam int StateWidth = 2;
    localparam int TicksWidth = 16;

    typedef enum logic [OpWidth-1:0] {
        OP_VOTE_ON  = 3'd0,
        OP_WITHDRAW = 3'd1,
        OP_ONLINE   = 3'd2,
        OP_CYCLE    = 3'd3,
        OP_CONFIRM  = 3'd4,
        OP_DONE     = 3'd5,
        OP_REPORT   = 3'd6,
        OP_TICK     = 3'd7
    } op_t;

    typedef enum logic [StateWidth-1:0] {
        RADIO_OFF     = 2'd0,
        RADIO_UNAVAIL = 2'd1,
        RADIO_ON      = 2'd2
    } radio_code_t;

    // One classified event as it travels from the decoder to the executor.
    typedef struct packed {
        op_t                   op;
        logic                  req_ok;
        logic [ReqIdWidth-1:0] requester;
        logic                  online;
        logic                  rs_valid;
        logic                  rs_on;
    } event_t;

endpackage

@@ rtl/rpc_if.sv @@
// Channel interfaces: event input, result output and retry count write.
interface rpc_event_if;
    logic                               valid;
    logic                               ready;
    logic [rpc_pkg::OpWidth-1:0]        op;
    logic [rpc_pkg::ReqIdWidth-1:0]     requester;
    logic                               online;
    logic [rpc_pkg::StateWidth-1:0]     modem_state;

    modport source (output valid, op, requester, online, modem_state, input ready);
    modport sink   (input valid, op, requester, online, modem_state, output ready);
endinterface

interface rpc_result_if;
    logic valid;
    logic ready;
    logic send_request;
    logic request_on;
    logic cancel_pending;
    logic public_state;
    logic state_changed;
    logic online_changed;
    logic busy_res;

    modport source (output valid, send_request, request_on, cancel_pending, public_state,
                    state_changed, online_changed, busy_res, input ready);
    modport sink   (input valid, send_request, request_on, cancel_pending, public_state,
                    state_changed, online_changed, busy_res, output ready);
endinterface

interface rpc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rpc_pkg::TicksWidth-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/rpc_front.sv @@
// Event decoder: classifies each incoming word before it is queued.
module rpc_front #(
    parameter int NUM_REQUESTERS = 16
) (
    rpc_event_if.sink       events,
    output logic            ev_valid,
    input  logic            ev_ready,
    output rpc_pkg::event_t ev
);

    localparam int CmpWidth = 32;

    always_comb
    begin
        ev.op        = rpc_pkg::op_t'(events.op);
        ev.requester = events.requester;
        // out-of-range requester indexes are dropped later
        ev.req_ok    = CmpWidth'(events.requester) < CmpWidth'(NUM_REQUESTERS);
        ev.online    = events.online;
        ev.rs_valid  = events.modem_state != rpc_pkg::RADIO_UNAVAIL;
        // an unknown code counts as on
        ev.rs_on     = events.modem_state != rpc_pkg::RADIO_OFF;
    end

    assign ev_valid     = events.valid;
    assign events.ready = ev_ready;

endmodule

@@ rtl/rpc_queue.sv @@
// Two-entry queue between the decoder and the executor.
module rpc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rpc_pkg::event_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rpc_pkg::event_t rd_data
);

    localparam int Depth    = 2;
    localparam int PtrWidth = $clog2(Depth);
    localparam int CntWidth = $clog2(Depth + 1);

    rpc_pkg::event_t       mem_reg [Depth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0]   count_reg, count_next;
    logic                  push, pop;

    assign wr_ready = count_reg != CntWidth'(Depth);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/rpc_exec.sv @@
// Executor: power request state, retry countdown and the result register.
module rpc_exec #(
    parameter int NUM_REQUESTERS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ev_valid,
    output logic            ev_ready,
    input  rpc_pkg::event_t ev,
    rpc_cfg_if.sink         cfg,
    rpc_result_if.source    results
);

    typedef struct packed {
        logic                           pending;
        logic                           q_valid;
        logic                           q_on;
        logic                           armed;
        logic [rpc_pkg::TicksWidth-1:0] left;
        logic                           chg;
        logic                           cycle;
        logic                           last_on;
        logic                           shown_on;
        logic                           send;
        logic                           req_on;
        logic                           cancel;
        logic                           st_chg;
    } ctl_t;

    typedef logic [rpc_pkg::TicksWidth-1:0] ticks_t;

    function automatic ctl_t do_issue(ctl_t s, logic on);
        ctl_t r;
        r         = s;
        r.q_valid = 1'b0;
        r.q_on    = on;
        r.chg     = 1'b0;
        r.armed   = 1'b0;
        r.left    = '0;
        r.pending = 1'b1;
        r.send    = 1'b1;
        r.req_on  = on;
        return r;
    endfunction

    function automatic ctl_t do_eval(ctl_t s, logic demand, ticks_t retry);
        ctl_t r;
        logic w;
        r = s;
        w = demand && !s.cycle;
        if (!r.pending)
        begin
            if (r.last_on == w)
            begin
                r.armed = 1'b0;
                r.left  = '0;
            end
            else if (r.chg)
            begin
                r = do_issue(r, w);
            end
            else if (!r.armed)
            begin
                r.armed = 1'b1;
                r.left  = retry;
            end
        end
        // publish only once things have settled
        if (!r.pending && !r.armed && r.shown_on != r.last_on)
        begin
            r.shown_on = r.last_on;
            r.st_chg   = 1'b1;
        end
        return r;
    endfunction

    function automatic ctl_t do_finish(ctl_t s, logic demand, ticks_t retry);
        ctl_t r;
        r         = s;
        r.pending = 1'b0;
        if (r.q_valid)
        begin
            r = do_issue(r, r.q_on);
        end
        else
        begin
            r = do_eval(r, demand, retry);
        end
        return r;
    endfunction

    function automatic ctl_t do_power(ctl_t s, logic on, logic repeat_req, logic demand,
                                      ticks_t retry);
        ctl_t r;
        r = s;
        if (r.pending)
        begin
            if (repeat_req || r.q_on != on)
            begin
                r.q_valid = 1'b1;
                r.q_on    = on;
            end
        end
        else if (r.last_on == on)
        begin
            r = do_eval(r, demand, retry);
        end
        else
        begin
            r = do_issue(r, on);
        end
        return r;
    endfunction

    logic [NUM_REQUESTERS-1:0] mask_reg, mask_next;
    logic                      online_reg, online_next;
    ctl_t                      ctl_reg, ctl_next;
    ticks_t                    retry_reg;
    logic                      res_valid_reg;
    logic                      online_chg_reg, online_chg_next;
    logic                      take;

    assign ev_ready  = !res_valid_reg || results.ready;
    assign take      = ev_valid && ev_ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        logic [NUM_REQUESTERS-1:0] bit_sel;
        logic                      demand_old;
        logic                      demand_new;
        logic                      was_on;
        logic                      now_on;
        logic                      st;

        bit_sel         = NUM_REQUESTERS'(1) << ev.requester;
        demand_old      = online_reg || (mask_reg != '0);
        mask_next       = mask_reg;
        online_next     = online_reg;
        online_chg_next = 1'b0;
        ctl_next        = ctl_reg;
        ctl_next.send   = 1'b0;
        ctl_next.req_on = 1'b0;
        ctl_next.cancel = 1'b0;
        ctl_next.st_chg = 1'b0;
        demand_new      = demand_old;
        was_on          = 1'b0;
        now_on          = 1'b0;
        st              = ev.rs_on;

        case (ev.op)
            rpc_pkg::OP_VOTE_ON:
            begin
                if (ev.req_ok && (mask_reg & bit_sel) == '0)
                begin
                    was_on     = demand_old && !ctl_reg.cycle;
                    mask_next  = mask_reg | bit_sel;
                    demand_new = 1'b1;
                    now_on     = !ctl_reg.cycle;
                    if (!was_on && now_on)
                    begin
                        ctl_next = do_power(ctl_next, 1'b1, 1'b0, demand_new, retry_reg);
                    end
                end
            end
            rpc_pkg::OP_WITHDRAW:
            begin
                if (ev.req_ok && (mask_reg & bit_sel) != '0)
                begin
                    mask_next  = mask_reg & ~bit_sel;
                    demand_new = online_reg || (mask_next != '0);
                    if (!(demand_new && !ctl_reg.cycle))
                    begin
                        ctl_next = do_power(ctl_next, 1'b0, 1'b0, demand_new, retry_reg);
                    end
                end
            end
            rpc_pkg::OP_ONLINE:
            begin
                if (online_reg != ev.online)
                begin
                    was_on          = demand_old && !ctl_reg.cycle;
                    online_next     = ev.online;
                    demand_new      = ev.online || (mask_reg != '0);
                    now_on          = demand_new && !ctl_reg.cycle;
                    online_chg_next = 1'b1;
                    if (was_on != now_on)
                    begin
                        ctl_next = do_power(ctl_next, now_on, 1'b0, demand_new, retry_reg);
                    end
                end
            end
            rpc_pkg::OP_CYCLE:
            begin
                if (ctl_reg.last_on && !ctl_reg.cycle)
                begin
                    ctl_next.cycle = 1'b1;
                    if (!ctl_reg.pending)
                    begin
                        ctl_next = do_issue(ctl_next, 1'b0);
                    end
                end
            end
            rpc_pkg::OP_CONFIRM:
            begin
                if (demand_old && !ctl_reg.cycle)
                begin
                    ctl_next = do_power(ctl_next, 1'b1, 1'b1, demand_old, retry_reg);
                end
            end
            rpc_pkg::OP_DONE:
            begin
                if (ctl_reg.pending)
                begin
                    ctl_next = do_finish(ctl_next, demand_old, retry_reg);
                end
            end
            rpc_pkg::OP_REPORT:
            begin
                if (ev.rs_valid)
                begin
                    if (ctl_reg.cycle && !st)
                    begin
                        ctl_next.cycle = 1'b0;
                    end
                    ctl_next.last_on = st;
                    if (ctl_reg.pending && st == (demand_old && !ctl_next.cycle))
                    begin
                        // modem already reached the target: drop the request
                        ctl_next.cancel = 1'b1;
                        ctl_next        = do_finish(ctl_next, demand_old, retry_reg);
                    end
                    else
                    begin
                        if (ctl_reg.pending)
                        begin
                            ctl_next.chg = 1'b1;
                        end
                        ctl_next = do_eval(ctl_next, demand_old, retry_reg);
                    end
                end
            end
            rpc_pkg::OP_TICK:
            begin
                if (ctl_reg.armed)
                begin
                    if (ctl_reg.left <= ticks_t'(1))
                    begin
                        ctl_next = do_issue(ctl_next, demand_old && !ctl_reg.cycle);
                    end
                    else
                    begin
                        ctl_next.left = ctl_reg.left - 1'b1;
                    end
                end
            end
            default:
            begin
                ctl_next = ctl_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            online_reg     <= 1'b0;
            ctl_reg        <= '0;
            retry_reg      <= ticks_t'(1);
            res_valid_reg  <= 1'b0;
            online_chg_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                retry_reg <= cfg.data;
            end
            if (take)
            begin
                mask_reg       <= mask_next;
                online_reg     <= online_next;
                ctl_reg        <= ctl_next;
                online_chg_reg <= online_chg_next;
                res_valid_reg  <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.send_request   = ctl_reg.send;
    assign results.request_on     = ctl_reg.req_on;
    assign results.cancel_pending = ctl_reg.cancel;
    assign results.public_state   = ctl_reg.shown_on;
    assign results.state_changed  = ctl_reg.st_chg;
    assign results.online_changed = online_chg_reg;
    assign results.busy_res       = ctl_reg.pending || ctl_reg.armed;

endmodule

@@ rtl/radio_power_request_controller.sv @@
// Top level of the radio power request controller.
// One event word enters per cycle while results are taken; each yields one result:
// the decoder writes the classified event into a two-entry queue, and the executor
// applies it to the power request state and holds the result in its output register.
// Throughput is one event per cycle while results are taken; the queue lets the input
// keep flowing for two words while the result side is stalled. The retry count may
// be written at any time the block is idle and resets to 1.
module radio_power_request_controller #(
    parameter int NUM_REQUESTERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    rpc_event_if.sink    events,
    rpc_cfg_if.sink      cfg,
    rpc_result_if.source results
);

    logic            dec_valid;
    logic            dec_ready;
    rpc_pkg::event_t dec_ev;
    logic            q_valid;
    logic            q_ready;
    rpc_pkg::event_t q_ev;

    rpc_front #(
        .NUM_REQUESTERS (NUM_REQUESTERS)
    ) u_front (
        .events   (events),
        .ev_valid (dec_valid),
        .ev_ready (dec_ready),
        .ev       (dec_ev)
    );

    rpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (dec_valid),
        .wr_ready (dec_ready),
        .wr_data  (dec_ev),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_ev)
    );

    rpc_exec #(
        .NUM_REQUESTERS (NUM_REQUESTERS)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (q_valid),
        .ev_ready (q_ready),
        .ev       (q_ev),
        .cfg      (cfg),
        .results  (results)
    );

endmodule

@@ rtl/rpc_checker.sv @@
// Port-level checks for the radio power request controller, bound to the top level.
module rpc_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic send_request,
    input logic request_on,
    input logic cancel_pending,
    input logic public_state,
    input logic state_changed,
    input logic online_changed,
    input logic busy_res
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({send_request, request_on,
            cancel_pending, public_state, state_changed, online_changed, busy_res}))
        else $error("result word changed while stalled");

    a_req_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_request |-> !request_on)
        else $error("request level set without a request");

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_request |-> busy_res)
        else $error("request sent but block not busy");

    a_publish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && state_changed |-> !busy_res)
        else $error("public state changed while busy");

endmodule

bind radio_power_request_controller rpc_checker u_rpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .send_request   (results.send_request),
    .request_on     (results.request_on),
    .cancel_pending (results.cancel_pending),
    .public_state   (results.public_state),
    .state_changed  (results.state_changed),
    .online_changed (results.online_changed),
    .busy_res       (results.busy_res)
);

@@ sim/radio_power_request_controller_test.sv @@
// Self-checking testbench for the radio power request controller: directed and random events.
module radio_power_request_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRequesters = 16;
    localparam int CycleLimit    = 200000;
    localparam int DrainCycles   = 8;

    typedef logic [rpc_pkg::ReqIdWidth-1:0] req_id_t;
    typedef logic [rpc_pkg::StateWidth-1:0] modem_code_t;
    typedef logic [rpc_pkg::TicksWidth-1:0] ticks_t;

    localparam modem_code_t RadioUnknown = 2'd3;

    typedef struct packed {
        logic send_request;
        logic request_on;
        logic cancel_pending;
        logic public_state;
        logic state_changed;
        logic online_changed;
        logic busy_res;
    } power_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rpc_event_if  event_bus ();
    rpc_cfg_if    cfg_bus ();
    rpc_result_if result_bus ();

    radio_power_request_controller #(
        .NUM_REQUESTERS (NumRequesters)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (event_bus),
        .cfg     (cfg_bus),
        .results (result_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Power controller state as the testbench expects it
    logic [NumRequesters-1:0] votes           = '0;
    logic                     online_on       = 1'b0;
    logic                     req_out         = 1'b0;
    logic                     next_valid      = 1'b0;
    logic                     next_on         = 1'b0;
    logic                     retry_on        = 1'b0;
    ticks_t                   retry_count     = '0;
    logic                     moved_while_out = 1'b0;
    logic                     cycling         = 1'b0;
    logic                     modem_on        = 1'b0;
    logic                     shown_on        = 1'b0;
    ticks_t                   retry_period    = 16'd1;

    logic f_send, f_req_on, f_cancel, f_state_chg, f_online_chg;

    power_result_t expected_results[$];
    int            mismatches    = 0;
    int            cycle_count   = 0;
    int            src_idle_pct  = 0;
    int            sink_idle_pct = 0;
    int            hold_left     = 0;

    function automatic logic wants_power();
        return (online_on || votes != '0) && !cycling;
    endfunction

    function automatic void launch(logic on);
        next_valid      = 1'b0;
        next_on         = on;
        moved_while_out = 1'b0;
        retry_on        = 1'b0;
        retry_count     = '0;
        req_out         = 1'b1;
        f_send          = 1'b1;
        f_req_on        = on;
    endfunction

    // Re-check modem against the wanted level; publish once nothing is outstanding.
    function automatic void settle();
        logic w;
        if (!req_out)
        begin
            w = wants_power();
            if (modem_on == w)
            begin
                retry_on    = 1'b0;
                retry_count = '0;
            end
            else if (moved_while_out)
                launch(w);
            else if (!retry_on)
            begin
                retry_on    = 1'b1;
                retry_count = retry_period;
            end
        end
        if (!req_out && !retry_on && shown_on != modem_on)
        begin
            shown_on    = modem_on;
            f_state_chg = 1'b1;
        end
    endfunction

    function automatic void close_request();
        req_out = 1'b0;
        if (next_valid)
            launch(next_on);
        else
            settle();
    endfunction

    function automatic void ask_power(logic on, logic again);
        if (req_out)
        begin
            if (again || next_on != on)
            begin
                next_valid = 1'b1;
                next_on    = on;
            end
        end
        else if (modem_on == on)
            settle();
        else
            launch(on);
    endfunction

    function automatic power_result_t apply_event(rpc_pkg::op_t op, req_id_t rq,
                                                  logic onl, modem_code_t rs);
        power_result_t r;
        logic was, now, st;
        f_send       = 1'b0;
        f_req_on     = 1'b0;
        f_cancel     = 1'b0;
        f_state_chg  = 1'b0;
        f_online_chg = 1'b0;
        case (op)
            rpc_pkg::OP_VOTE_ON:
                if (int'(rq) < NumRequesters && !votes[rq])
                begin
                    was       = wants_power();
                    votes[rq] = 1'b1;
                    if (!was && wants_power())
                        ask_power(1'b1, 1'b0);
                end
            rpc_pkg::OP_WITHDRAW:
                if (int'(rq) < NumRequesters && votes[rq])
                begin
                    votes[rq] = 1'b0;
                    if (!wants_power())
                        ask_power(1'b0, 1'b0);
                end
            rpc_pkg::OP_ONLINE:
                if (online_on != onl)
                begin
                    was       = wants_power();
                    online_on = onl;
                    now       = wants_power();
                    if (was != now)
                        ask_power(now, 1'b0);
                    f_online_chg = 1'b1;
                end
            rpc_pkg::OP_CYCLE:
                if (modem_on && !cycling)
                begin
                    cycling = 1'b1;
                    if (!req_out)
                        launch(1'b0);
                end
            rpc_pkg::OP_CONFIRM:
                if (wants_power())
                    ask_power(1'b1, 1'b1);
            rpc_pkg::OP_DONE:
                if (req_out)
                    close_request();
            rpc_pkg::OP_REPORT:
                if (rs != rpc_pkg::RADIO_UNAVAIL)
                begin
                    st = (rs != rpc_pkg::RADIO_OFF);
                    if (cycling && !st)
                        cycling = 1'b0;
                    modem_on = st;
                    // drop the outstanding request once the modem already sits at target
                    if (req_out && st == wants_power())
                    begin
                        f_cancel = 1'b1;
                        close_request();
                    end
                    else
                    begin
                        if (req_out)
                            moved_while_out = 1'b1;
                        settle();
                    end
                end
            default:
                if (retry_on)
                begin
                    if (retry_count <= 1)
                    begin
                        retry_on    = 1'b0;
                        retry_count = '0;
                        launch(wants_power());
                    end
                    else
                        retry_count = retry_count - 1'b1;
                end
        endcase
        r.send_request   = f_send;
        r.request_on     = f_req_on;
        r.cancel_pending = f_cancel;
        r.public_state   = shown_on;
        r.state_changed  = f_state_chg;
        r.online_changed = f_online_chg;
        r.busy_res       = req_out || retry_on;
        return r;
    endfunction

    // Offer one event word; valid stays high after acceptance until the next falling edge.
    task automatic send_event(rpc_pkg::op_t op, req_id_t rq, logic onl, modem_code_t rs);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            event_bus.valid <= 1'b0;
            @(negedge clk);
        end
        event_bus.valid       <= 1'b1;
        event_bus.op          <= op;
        event_bus.requester   <= rq;
        event_bus.online      <= onl;
        event_bus.modem_state <= rs;
        do
            @(posedge clk);
        while (!(event_bus.valid && event_bus.ready));
        expected_results.push_back(apply_event(op, rq, onl, rs));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        event_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_retry_ticks(ticks_t ticks);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= ticks;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        retry_period = ticks;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void check_flag(string name, logic want, logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        power_result_t want;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word arrived with no event outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_flag("send_request", want.send_request, result_bus.send_request);
                check_flag("request_on", want.request_on, result_bus.request_on);
                check_flag("cancel_pending", want.cancel_pending, result_bus.cancel_pending);
                check_flag("public_state", want.public_state, result_bus.public_state);
                check_flag("state_changed", want.state_changed, result_bus.state_changed);
                check_flag("online_changed", want.online_changed, result_bus.online_changed);
                check_flag("busy_res", want.busy_res, result_bus.busy_res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed_events();
        write_retry_ticks(16'd2);
        // modem comes up unasked: arm retry, then let it fire an off request
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_ON);
        send_event(rpc_pkg::OP_TICK, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_TICK, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_UNAVAIL);
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_DONE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_VOTE_ON, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_VOTE_ON, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_VOTE_ON, 4'd15, 1'b1, rpc_pkg::RADIO_ON);
        send_event(rpc_pkg::OP_CONFIRM, 4'd15, 1'b1, RadioUnknown);
        send_event(rpc_pkg::OP_REPORT, 4'd15, 1'b1, RadioUnknown);
        send_event(rpc_pkg::OP_DONE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_ON);
        send_event(rpc_pkg::OP_CYCLE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_CYCLE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_DONE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_ONLINE, 4'd0, 1'b1, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_ONLINE, 4'd0, 1'b1, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_ONLINE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_WITHDRAW, 4'd15, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_WITHDRAW, 4'd15, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_WITHDRAW, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_TICK, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        wait_for_results();
    endtask

    // A zero retry count must fire on the first tick.
    task automatic test_zero_retry_ticks();
        write_retry_ticks(16'd0);
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_ON);
        send_event(rpc_pkg::OP_TICK, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_REPORT, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_DONE, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        send_event(rpc_pkg::OP_TICK, 4'd0, 1'b0, rpc_pkg::RADIO_OFF);
        wait_for_results();
    endtask

    task automatic test_random_traffic(int src_idle, int sink_idle, ticks_t ticks, int count);
        int           pick;
        rpc_pkg::op_t op;
        req_id_t      rq;
        modem_code_t  rs;
        write_retry_ticks(ticks);
        src_idle_pct  = src_idle;
        sink_idle_pct = sink_idle;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 16)      op = rpc_pkg::OP_VOTE_ON;
            else if (pick < 30) op = rpc_pkg::OP_WITHDRAW;
            else if (pick < 37) op = rpc_pkg::OP_ONLINE;
            else if (pick < 41) op = rpc_pkg::OP_CYCLE;
            else if (pick < 46) op = rpc_pkg::OP_CONFIRM;
            else if (pick < 58) op = rpc_pkg::OP_DONE;
            else if (pick < 78) op = rpc_pkg::OP_REPORT;
            else                op = rpc_pkg::OP_TICK;
            // few requesters most of the time, so withdraws find a set vote
            rq = req_id_t'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3));
            // modem mostly answers with the level last asked for
            pick = $urandom_range(99);
            if (pick < 70)      rs = next_on ? rpc_pkg::RADIO_ON : rpc_pkg::RADIO_OFF;
            else if (pick < 80) rs = rpc_pkg::RADIO_UNAVAIL;
            else                rs = modem_code_t'($urandom_range(3));
            send_event(op, rq, 1'($urandom_range(1)), rs);
        end
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        write_retry_ticks(16'd4);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_left     = 60;
        for (int i = 0; i < 30; i++)
            send_event(rpc_pkg::op_t'($urandom_range(7)), req_id_t'($urandom_range(15)),
                       1'($urandom_range(1)), modem_code_t'($urandom_range(3)));
        // pause the sender until the pipe is empty, then resume
        wait_for_results();
        for (int i = 0; i < 10; i++)
            send_event(rpc_pkg::op_t'($urandom_range(7)), req_id_t'($urandom_range(15)),
                       1'($urandom_range(1)), modem_code_t'($urandom_range(3)));
        wait_for_results();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        event_bus.valid        = 1'b0;
        event_bus.op           = rpc_pkg::OP_VOTE_ON;
        event_bus.requester    = '0;
        event_bus.online       = 1'b0;
        event_bus.modem_state  = rpc_pkg::RADIO_OFF;
        cfg_bus.valid          = 1'b0;
        cfg_bus.data           = '0;
        result_bus.ready       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_events();
        test_zero_retry_ticks();
        test_random_traffic(34, 84, 16'd1, 620);
        test_random_traffic(84, 34, 16'hFFFF, 620);
        test_random_traffic(0, 0, 16'd3, 620);
        test_result_backpressure();

        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
